// ----- src/integer_to_radix_digits_core_assert.svh -----
// Assertion macros shared by the radix digit conversion modules.
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// Check that a property holds on every clock edge outside reset.
`define RITD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never becomes true outside reset.
`define RITD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/ritd_pkg.sv -----
// Shared types, constants and functions of the radix digit converter.
package ritd_pkg;

	localparam int VALUE_BITS_DEF = 63;
	localparam int RADIX_W        = 6;
	localparam int DIGIT_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int OUT_DATA_W     = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [DIGIT_W-1:0] DECIMAL_SPLIT = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = 7'd65;

	typedef struct packed {
		logic valid;
		logic bits;
	} carry_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	function automatic logic [RADIX_W-1:0] radix_sat_f(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char_f(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DECIMAL_SPLIT) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = CHAR_ALPHA + CHAR_W'(d - DECIMAL_SPLIT);
		end
		return res;
	endfunction

endpackage

// ----- src/ritd_cell.sv -----
// One digit cell: doubles its digit plus an incoming carry modulo the radix, or clears, or loads a shifted-in digit.
module ritd_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ritd_pkg::cell_ctrl_t           ctrl,
	input  logic [ritd_pkg::RADIX_W-1:0]   radix,
	input  logic [ritd_pkg::DIGIT_W-1:0]   digit_in,
	input  ritd_pkg::carry_t               cin,
	output logic [ritd_pkg::DIGIT_W-1:0]   digit,
	output ritd_pkg::carry_t               cout
);
	import ritd_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	carry_t             carry_q;
	logic [DIGIT_W:0]   sum;
	logic               ge;
	logic [DIGIT_W:0]   diff;

	// digit < radix, so 2*digit+1 < 2*radix and one subtract suffices
	assign sum  = {digit_q, cin.bits};
	assign ge   = sum >= {1'b0, radix};
	assign diff = sum - {1'b0, radix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (ctrl.clear || ctrl.shift) begin
			carry_q <= '0;
		end else begin
			carry_q.valid <= cin.valid;
			carry_q.bits  <= cin.valid & ge;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end else if (cin.valid) begin
			digit_q <= ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
		end
	end

	assign digit = digit_q;
	assign cout  = carry_q;

endmodule

// ----- src/ritd_chain.sv -----
// Row of digit cells; carries move one cell per cycle, digits shift up to emit.
`include "integer_to_radix_digits_core_assert.svh"

module ritd_chain #(
	parameter int VALUE_BITS = ritd_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ritd_pkg::cell_ctrl_t         ctrl,
	input  logic [ritd_pkg::RADIX_W-1:0] radix,
	input  ritd_pkg::carry_t             feed,
	output logic [ritd_pkg::DIGIT_W-1:0] top_digit
);
	import ritd_pkg::*;

	logic [DIGIT_W-1:0] digit_w [VALUE_BITS];
	carry_t             carry_w [VALUE_BITS+1];

	assign carry_w[0] = feed;

	for (genvar k = 0; k < VALUE_BITS; k++) begin : g_cell
		logic [DIGIT_W-1:0] din;
		if (k == 0) begin : g_first
			assign din = '0;
		end else begin : g_next
			assign din = digit_w[k-1];
		end
		ritd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.radix    (radix),
			.digit_in (din),
			.cin      (carry_w[k]),
			.digit    (digit_w[k]),
			.cout     (carry_w[k+1])
		);
	end

	assign top_digit = digit_w[VALUE_BITS-1];

	// the top cell can never overflow: VALUE_BITS digits cover any value at radix 2
	`RITD_NEVER(a_no_overflow, carry_w[VALUE_BITS].valid && carry_w[VALUE_BITS].bits,
		"carry left the top digit cell")

endmodule

// ----- src/integer_to_radix_digits_core.sv -----
// The value is fed in MSB first and the carries drain through the chain, then one digit per cycle
// leaves while the receiver does not stall; up to VALUE_BITS-1 leading zero digits are dropped first.
// A new number is accepted only in idle, once the last digit of the previous one is loaded into the
// output register; receiver stalls delay that.
// Reset (arst_n low, asynchronous): controller to idle, output and carry valids cleared.
`include "integer_to_radix_digits_core_assert.svh"

module integer_to_radix_digits_core #(
	parameter int VALUE_BITS = ritd_pkg::VALUE_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// slave side tdata, from bit 0 up: value, radix, zero padding
	input  logic [((VALUE_BITS+ritd_pkg::RADIX_W+7)/8)*8-1:0] s_tdata,
	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	// master side tdata, from bit 0 up: digit_char, zero padding
	output logic [ritd_pkg::OUT_DATA_W-1:0]                m_tdata,
	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	// last_digit: marks the least significant digit of the number
	output logic                                           m_tlast
);
	import ritd_pkg::*;

	localparam int CNT_W    = $clog2(2*VALUE_BITS);
	localparam int REM_W    = $clog2(VALUE_BITS+1);
	localparam int CNT_LAST = 2*VALUE_BITS-2;

	state_t               state_q, state_d;
	logic [VALUE_BITS-1:0] value_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [REM_W-1:0]     rem_q, rem_d;
	logic                 started_q, started_d;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 skip;
	logic                 load_out;
	logic                 out_free;
	logic                 feeding;
	cell_ctrl_t           ctrl;
	carry_t               feed;
	logic [DIGIT_W-1:0]   top_digit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// the value enters MSB first, one bit per cycle, until all VALUE_BITS bits are in
	assign feeding    = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_BITS));
	assign feed.valid = feeding;
	assign feed.bits  = feeding & value_q[VALUE_BITS-1];

	// skip drops leading zero digits; the final digit is always sent, so zero gives '0'
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		started_d = started_q;
		skip      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d   = ST_CONV;
					cnt_d     = '0;
					started_d = 1'b0;
				end
			end
			ST_CONV: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CNT_LAST)) begin
					state_d = ST_EMIT;
					rem_d   = REM_W'(VALUE_BITS);
				end
			end
			ST_EMIT: begin
				if (!started_q && top_digit == '0 && rem_q != REM_W'(1)) begin
					skip  = 1'b1;
					rem_d = rem_q - REM_W'(1);
				end else if (out_free) begin
					load_out  = 1'b1;
					started_d = 1'b1;
					rem_d     = rem_q - REM_W'(1);
					if (rem_q == REM_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ctrl.clear = accept;
	assign ctrl.shift = skip || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rem_q     <= rem_d;
			started_q <= started_d;
		end
	end

	// hold the value for shifting out, the saturated radix for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= s_tdata[VALUE_BITS-1:0];
			radix_q <= radix_sat_f(s_tdata[VALUE_BITS +: RADIX_W]);
		end else if (feeding) begin
			value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// output register: a waiting digit does not block the next input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= digit_char_f(top_digit);
			out_last_q <= (rem_q == REM_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, out_char_q};
	assign m_tlast  = out_last_q;

	ritd_chain #(
		.VALUE_BITS (VALUE_BITS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.radix     (radix_q),
		.feed      (feed),
		.top_digit (top_digit)
	);

	`RITD_ASSERT(a_accept_starts, accept |=> (state_q == ST_CONV) && (cnt_q == '0),
		"accepted transfer did not start a conversion")
	`RITD_NEVER(a_rem_zero, (state_q == ST_EMIT) && (rem_q == '0),
		"digit countdown ran out while emitting")
	`RITD_ASSERT(a_char_range, m_tvalid |-> (out_char_q >= CHAR_ZERO) && (out_char_q <= 7'd90),
		"digit character out of range")
	`RITD_ASSERT(a_last_sent, (state_q == ST_EMIT) && (rem_q == REM_W'(1)) |-> !skip,
		"final digit was dropped")

endmodule

// ----- test/tb_top.sv -----
// Testbench of integer_to_radix_digits_core: directed and random numbers, digit stream checks.
`timescale 1ns / 100ps

module tb_top;

	localparam int VALUE_BITS   = 63;
	localparam int IN_W         = ((VALUE_BITS + ritd_pkg::RADIX_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 90;
	// one item at worst: conversion plus 63 digits, each waiting out a full receiver stall
	localparam int DRAIN_CYCLES = 700;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [ritd_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} digit_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [ritd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 m_tlast;

	// newest digit at the front, oldest at the back
	digit_t expected_digits[$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	bit     idle_on = 1'b1;
	int     ready_wait = 0;

	integer_to_radix_digits_core #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Queue the digits of one number, most significant first.
	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
		input logic [ritd_pkg::RADIX_W-1:0] r);
		logic [ritd_pkg::RADIX_W-1:0] base;
		logic [VALUE_BITS-1:0]        rest;
		logic [ritd_pkg::DIGIT_W-1:0] d;
		logic [ritd_pkg::CHAR_W-1:0]  msd_first[$];
		digit_t                       item;
		base = r;
		if (base < ritd_pkg::RADIX_MIN) base = ritd_pkg::RADIX_MIN;
		if (base > ritd_pkg::RADIX_MAX) base = ritd_pkg::RADIX_MAX;
		rest = v;
		if (rest == 0) msd_first.push_front(ritd_pkg::CHAR_ZERO);
		while (rest != 0) begin
			d = ritd_pkg::DIGIT_W'(rest % base);
			rest = rest / base;
			if (d < ritd_pkg::DECIMAL_SPLIT)
				msd_first.push_front(ritd_pkg::CHAR_ZERO + ritd_pkg::CHAR_W'(d));
			else
				msd_first.push_front(ritd_pkg::CHAR_ALPHA +
					ritd_pkg::CHAR_W'(d - ritd_pkg::DECIMAL_SPLIT));
		end
		for (int k = 0; k < msd_first.size(); k++) begin
			item.ch = msd_first[k];
			item.last = (k == msd_first.size() - 1);
			expected_digits.push_front(item);
		end
	endfunction

	// Called at a rising edge; returns at the edge that accepts the transfer.
	task automatic send_number(input logic [VALUE_BITS-1:0] v,
		input logic [ritd_pkg::RADIX_W-1:0] r);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= IN_W'({r, v});
		s_tvalid <= 1'b1;
		do @(negedge clk); while (!s_tready);
		predict_digits(v, r);
		@(posedge clk);
	endtask

	// Hold off the sender until every queued digit has come out.
	task automatic drain_digits();
		s_tvalid <= 1'b0;
		while (expected_digits.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stall before each transfer while idling is on, compare against the oldest digit.
	always @(posedge clk) begin
		digit_t want;
		logic   take;
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_wait = 0;
		end else begin
			take = m_tvalid && m_tready;
			if (take) begin
				if (expected_digits.size() == 0) begin
					report_mismatch($sformatf("unexpected digit 0x%02h last=%0b",
						m_tdata, m_tlast));
				end else begin
					want = expected_digits.pop_back();
					if (m_tdata[ritd_pkg::CHAR_W-1:0] !== want.ch)
						report_mismatch($sformatf("digit_char 0x%02h, want 0x%02h",
							m_tdata[ritd_pkg::CHAR_W-1:0], want.ch));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last_digit %0b, want %0b",
							m_tlast, want.last));
				end
				ready_wait = idle_on ? $urandom_range(0, 7) : 0;
			end
			if (take || !m_tready) begin
				if (ready_wait == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					ready_wait--;
				end
			end
		end
	end

	task automatic test_extremes();
		logic [VALUE_BITS-1:0] all_ones;
		all_ones = '1;
		send_number('0, 6'd2);
		send_number('0, 6'd10);
		send_number('0, 6'd36);
		send_number('0, 6'd0);
		send_number(63'd1, 6'd2);
		send_number(all_ones, 6'd2);
		send_number(all_ones, 6'd36);
		send_number(all_ones, 6'd10);
		send_number(63'd1 << 62, 6'd2);
		send_number(63'h5555_5555_5555_5555, 6'd16);
		send_number(63'h2AAA_AAAA_AAAA_AAAA, 6'd8);
		// saturated radix: below two acts as binary, above thirty-six as base 36
		send_number(63'd5, 6'd0);
		send_number(63'd5, 6'd1);
		send_number(63'd1295, 6'd37);
		send_number(all_ones, 6'd63);
		send_number(63'd35, 6'd36);
		send_number(63'd9, 6'd11);
		send_number(63'd10, 6'd11);
		send_number(63'd35, 6'd35);
		send_number(63'd1000, 6'd10);
		send_number(63'd4095, 6'd3);
		drain_digits();
	endtask

	task automatic test_pressure();
		for (int i = 0; i < 6; i++)
			send_number(63'($urandom), 6'($urandom_range(2, 36)));
		drain_digits();
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 0; i < 4; i++)
			send_number(63'($urandom_range(0, 50)), 6'($urandom_range(2, 36)));
		drain_digits();
	endtask

	task automatic test_random();
		logic [63:0] raw;
		logic [5:0]  r;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// stretch with no idling on either side
			idle_on = !(i >= 20 && i < 45);
			raw = {$urandom, $urandom} >> $urandom_range(0, 63);
			if ($urandom_range(0, 9) == 0)
				r = 6'($urandom_range(0, 63));
			else
				r = 6'($urandom_range(2, 36));
			send_number(raw[VALUE_BITS-1:0], r);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_pressure();
		test_random();
		drain_digits();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
